[src/indexed_list_insert_delete_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list block
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ILID_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ILID_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ILID_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define ILID_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

[src/ilid_pkg.sv]
// ----------------------------------------------------------------------------
// ilid_pkg
// Operation codes, field widths and control/status bundles of the list block.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

  localparam int MODE_W    = 3;
  localparam int POS_W     = 5;
  localparam int WORD_W    = 32;
  localparam int CNT_OUT_W = 5;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_GET    = 3'd2,
    MODE_SET    = 3'd3,
    MODE_DUMP   = 3'd4
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic start;  // input item taken, execute it and load the result
    logic step;   // load the next dump entry
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dump_multi;  // incoming item is a dump of more than one entry
    logic dump_last;   // the entry loaded on this step ends the dump
  } dp_stat_t;

endpackage

`default_nettype wire

[src/indexed_list_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top
// Bounded ordered list of data words addressed by position.
// ----------------------------------------------------------------------------
// Input stream (s_*): one item names an operation in s_tuser (insert,
// delete, get, set, dump) with a position and a data word in s_tdata.
// Output stream (m_*): every item gives one or more results; tlast marks
// the final result of an item. Each result carries status and the entry
// count after the operation; get and dump results carry a data word.
// The result is registered and shown in the cycle after the input is taken.
// Insert, delete, get and set each give a single result: the row of entry
// cells shifts or is written in place as the item is taken.
// Dump of N entries streams N results (1 if empty), one per cycle while
// the receiver is ready; the single read port of the cell row sets that rate.
// A new item is taken while the last result of the previous one waits,
// as long as the output register is freed in the same cycle.
// Reset clears the count (empty list) and the stream handshake; entries
// hold nothing until written. A stalled receiver holds the result and
// blocks further input.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // position[4:0], data_in[36:5], zero fill above
  input  wire logic [ilid_pkg::S_TDATA_W-1:0]    s_tdata,
  // mode[2:0]
  input  wire logic [ilid_pkg::MODE_W-1:0]       s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // status[0], data_out[32:1], entry_count[37:33], zero fill above
  output logic [ilid_pkg::M_TDATA_W-1:0]         m_tdata,
  // item_valid[0], first_item[1]
  output logic [1:0]                             m_tuser,
  output logic                                   m_tlast
);

  ilid_pkg::ctrl_cmd_t cmd;
  ilid_pkg::dp_stat_t  stat;

  logic                              status, item_valid, first_item;
  logic [ilid_pkg::WORD_W-1:0]       data_out;
  logic [ilid_pkg::CNT_OUT_W-1:0]    entry_count;

  ilid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilid_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (ilid_pkg::mode_t'(s_tuser)),
    .position    (s_tdata[ilid_pkg::POS_W-1:0]),
    .data_in     (s_tdata[ilid_pkg::POS_W +: ilid_pkg::WORD_W]),
    .status      (status),
    .data_out    (data_out),
    .item_valid  (item_valid),
    .first_item  (first_item),
    .last        (m_tlast),
    .entry_count (entry_count)
  );

  assign m_tdata = {2'b00, entry_count, data_out, status};
  assign m_tuser = {first_item, item_valid};

`include "indexed_list_insert_delete_top_assert.svh"

  // a dump in flight keeps the output stream fed after each handshake
  `ILID_ASSERT_NEXT(a_dump_continues, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid, "dump stream broke before its last entry")
  // input is only taken once any pending result closes its run
  `ILID_ASSERT_IMPL(a_ready_after_last, clk, rst, s_tready && m_tvalid, m_tlast, "input taken while a dump is still pending")
  // a new item and a dump step never load the result register together
  `ILID_ASSERT_IMPL(a_start_step_excl, clk, rst, cmd.start, !cmd.step, "start and dump step in the same cycle")

endmodule

`default_nettype wire

[src/ilid_ctrl.sv]
// ----------------------------------------------------------------------------
// ilid_ctrl
// Sequencer: input handshake, dump stepping and output register valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire ilid_pkg::dp_stat_t stat,
  output ilid_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   load_ok;

  // output register is free this cycle
  assign load_ok   = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && load_ok;
  assign cmd.start = s_tvalid && s_tready;
  assign cmd.step  = (state == ST_DUMP) && load_ok;
  assign m_tvalid  = out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start && stat.dump_multi) state_next = ST_DUMP;
      end
      ST_DUMP: begin
        if (cmd.step && stat.dump_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.start || cmd.step) out_valid_next = 1'b1;
    else if (m_tready)                  out_valid_next = 1'b0;
    else                                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[src/ilid_dp.sv]
// ----------------------------------------------------------------------------
// ilid_dp
// Datapath: row of entry cells with shift up/down, count, read mux and
// the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ilid_pkg::ctrl_cmd_t             cmd,
  output ilid_pkg::dp_stat_t                   stat,
  input  wire ilid_pkg::mode_t                 mode,
  input  wire logic [ilid_pkg::POS_W-1:0]      position,
  input  wire logic [ilid_pkg::WORD_W-1:0]     data_in,
  output logic                                 status,
  output logic [ilid_pkg::WORD_W-1:0]          data_out,
  output logic                                 item_valid,
  output logic                                 first_item,
  output logic                                 last,
  output logic [ilid_pkg::CNT_OUT_W-1:0]       entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
  localparam int WW = (DATA_WIDTH > ilid_pkg::WORD_W) ? DATA_WIDTH : ilid_pkg::WORD_W;

  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [DATA_WIDTH-1:0] up      [DEPTH];
  logic [DATA_WIDTH-1:0] down    [DEPTH];

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] didx;
  logic [WW-1:0] din_ext, dout_ext;
  logic [DATA_WIDTH-1:0] din, rd_data, o_data;
  logic [PW-1:0] pos_w, cnt_w;
  logic [IW-1:0] rd_idx;
  logic          in_range, ins_ok;
  logic          do_ins, do_del, do_set;
  logic          r_status, r_item, r_first, r_last;

  assign din_ext = WW'(data_in);
  assign din     = din_ext[DATA_WIDTH-1:0];
  assign pos_w   = PW'(position);
  assign cnt_w   = PW'(count);

  assign in_range = pos_w < cnt_w;
  assign ins_ok   = (din != '0) && (pos_w <= cnt_w) && (count < CW'(DEPTH));

  // neighbor taps for the shift on insert and delete
  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_lo
      assign up[g] = entries[g];
    end else begin : g_up
      assign up[g] = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign down[g] = entries[g];
    end else begin : g_dn
      assign down[g] = entries[g+1];
    end
  end

  // single read port: dump cursor, first entry of a dump, or the given position
  always_comb begin
    priority if (cmd.step)             rd_idx = didx[IW-1:0];
    else if (mode == ilid_pkg::MODE_DUMP) rd_idx = '0;
    else                               rd_idx = pos_w[IW-1:0];
  end
  assign rd_data = entries[rd_idx];

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_set     = 1'b0;
    r_status   = 1'b0;
    r_item     = 1'b0;
    r_first    = 1'b0;
    r_last     = 1'b1;
    count_next = count;
    unique case (mode)
      ilid_pkg::MODE_INSERT: begin
        do_ins   = ins_ok;
        r_status = !ins_ok;
        if (ins_ok) count_next = count + CW'(1);
      end
      ilid_pkg::MODE_DELETE: begin
        do_del   = in_range;
        r_status = !in_range;
        if (in_range) count_next = count - CW'(1);
      end
      ilid_pkg::MODE_GET: begin
        r_status = !in_range;
        r_item   = in_range;
      end
      ilid_pkg::MODE_SET: begin
        do_set   = in_range;
        r_status = !in_range;
      end
      ilid_pkg::MODE_DUMP: begin
        if (count != '0) begin
          r_item  = 1'b1;
          r_first = 1'b1;
          r_last  = (count == CW'(1));
        end
      end
      default: r_status = 1'b1;
    endcase
  end

  assign stat.dump_multi = (mode == ilid_pkg::MODE_DUMP) && (count > CW'(1));
  assign stat.dump_last  = ((didx + CW'(1)) == count);

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.start) begin
        if (do_ins) begin
          if (PW'(i) > pos_w)       entries[i] <= up[i];
          else if (PW'(i) == pos_w) entries[i] <= din;
        end else if (do_del) begin
          if (PW'(i) >= pos_w) entries[i] <= down[i];
        end else if (do_set) begin
          if (PW'(i) == pos_w) entries[i] <= din;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      didx  <= '0;
    end else if (cmd.start) begin
      count <= count_next;
      didx  <= CW'(1);
    end else if (cmd.step) begin
      didx  <= didx + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      status      <= r_status;
      o_data      <= r_item ? rd_data : '0;
      item_valid  <= r_item;
      first_item  <= r_first;
      last        <= r_last;
      entry_count <= ilid_pkg::CNT_OUT_W'(count_next);
    end else if (cmd.step) begin
      status      <= 1'b0;
      o_data      <= rd_data;
      item_valid  <= 1'b1;
      first_item  <= 1'b0;
      last        <= stat.dump_last;
    end
  end

  assign dout_ext = WW'(o_data);
  assign data_out = dout_ext[ilid_pkg::WORD_W-1:0];

endmodule

`default_nettype wire

[tb/sv/indexed_list_insert_delete_top_tb.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top_tb
// Self-checking bench for the bounded indexed list. A short table of
// directed items covers the empty list, edge values, bad positions, null
// inserts and undefined modes. Random grow/shrink sweeps then fill the store
// to the top and drain it again. Each item is run through a local list model
// and every result on the output stream is compared with the oldest expected
// result. Both stream sides insert random gaps.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int N_RANDOM = 125;
  localparam int N_DIRECTED = 25;

  // undefined operation codes, answered with an error
  localparam logic [ilid_pkg::MODE_W-1:0] MODE_RSV5 = 3'd5;
  localparam logic [ilid_pkg::MODE_W-1:0] MODE_RSV6 = 3'd6;
  localparam logic [ilid_pkg::MODE_W-1:0] MODE_RSV7 = 3'd7;

  typedef struct packed {
    logic                        status;
    logic [ilid_pkg::WORD_W-1:0] word;
    logic                        item_valid;
    logic                        first_item;
    logic                        last;
    logic [4:0]                  cnt;
  } list_result_t;

  // fixed = 1: single result typed in the row (no data, last set)
  typedef struct packed {
    logic [ilid_pkg::MODE_W-1:0] op;
    logic [ilid_pkg::POS_W-1:0]  pos;
    logic [ilid_pkg::WORD_W-1:0] word;
    logic                        fixed;
    logic                        f_status;
    logic [4:0]                  f_cnt;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [ilid_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [ilid_pkg::MODE_W-1:0]    s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [ilid_pkg::M_TDATA_W-1:0] m_tdata;
  logic [1:0]                     m_tuser;
  logic                           m_tlast;

  logic [ilid_pkg::WORD_W-1:0] list_mem [DEPTH];
  int                          list_len = 0;
  list_result_t                pending_q [$];

  int err_cnt = 0;
  int n_items = 0;
  int n_results = 0;
  int n_dumps = 0;
  int n_rejects = 0;
  int n_full_rejects = 0;
  int peak_len = 0;
  bit src_steady = 1'b0;
  bit snk_steady = 1'b0;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{ilid_pkg::MODE_DUMP,   5'd0,  32'h0000_0000, 1'b1, 1'b0, 5'd0},
    '{ilid_pkg::MODE_GET,    5'd0,  32'h0000_0000, 1'b1, 1'b1, 5'd0},
    '{ilid_pkg::MODE_DELETE, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 5'd0},
    '{ilid_pkg::MODE_SET,    5'd0,  32'h1234_5678, 1'b1, 1'b1, 5'd0},
    '{ilid_pkg::MODE_INSERT, 5'd1,  32'h0000_0005, 1'b1, 1'b1, 5'd0},
    '{ilid_pkg::MODE_INSERT, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 5'd0},
    '{ilid_pkg::MODE_INSERT, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 5'd1},
    '{ilid_pkg::MODE_INSERT, 5'd1,  32'h0000_0001, 1'b1, 1'b0, 5'd2},
    '{ilid_pkg::MODE_INSERT, 5'd0,  32'h8000_0000, 1'b1, 1'b0, 5'd3},
    '{ilid_pkg::MODE_INSERT, 5'd1,  32'h5555_5555, 1'b1, 1'b0, 5'd4},
    '{ilid_pkg::MODE_INSERT, 5'd5,  32'hAAAA_AAAA, 1'b1, 1'b1, 5'd4},
    '{ilid_pkg::MODE_GET,    5'd0,  32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{ilid_pkg::MODE_GET,    5'd3,  32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0},
    '{ilid_pkg::MODE_SET,    5'd2,  32'h0000_0000, 1'b1, 1'b0, 5'd4},
    '{ilid_pkg::MODE_GET,    5'd2,  32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{ilid_pkg::MODE_DUMP,   5'd0,  32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{MODE_RSV5,             5'd0,  32'h0000_0001, 1'b1, 1'b1, 5'd4},
    '{MODE_RSV6,             5'd3,  32'hDEAD_BEEF, 1'b1, 1'b1, 5'd4},
    '{MODE_RSV7,             5'd31, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd4},
    '{ilid_pkg::MODE_GET,    5'd16, 32'h0000_0000, 1'b1, 1'b1, 5'd4},
    '{ilid_pkg::MODE_DELETE, 5'd4,  32'h0000_0000, 1'b1, 1'b1, 5'd4},
    '{ilid_pkg::MODE_DELETE, 5'd3,  32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{ilid_pkg::MODE_DELETE, 5'd0,  32'h0000_0000, 1'b0, 1'b0, 5'd0},
    '{ilid_pkg::MODE_INSERT, 5'd2,  32'h0000_FFFF, 1'b0, 1'b0, 5'd0},
    '{ilid_pkg::MODE_DUMP,   5'd9,  32'h7777_7777, 1'b0, 1'b0, 5'd0}
  };

  indexed_list_insert_delete_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (ilid_pkg::WORD_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the local list; keep = 0 updates state only.
  function automatic void apply_list_op(input logic [ilid_pkg::MODE_W-1:0] op,
                                        input logic [ilid_pkg::POS_W-1:0] pos,
                                        input logic [ilid_pkg::WORD_W-1:0] word,
                                        input bit keep);
    list_result_t r;
    int k;
    bit bad;
    r = '0;
    r.last = 1'b1;
    bad = 1'b0;
    case (op)
      ilid_pkg::MODE_INSERT: begin
        bad = (word == '0) || (pos > list_len) || (list_len >= DEPTH);
        if (!bad) begin
          for (k = list_len; k > pos; k--)
            list_mem[k] = list_mem[k-1];
          list_mem[pos] = word;
          list_len++;
        end else if (list_len >= DEPTH) begin
          n_full_rejects++;
        end
      end
      ilid_pkg::MODE_DELETE: begin
        bad = (pos >= list_len);
        if (!bad) begin
          for (k = pos; k + 1 < list_len; k++)
            list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      ilid_pkg::MODE_GET: begin
        bad = (pos >= list_len);
        if (!bad) begin
          r.word = list_mem[pos];
          r.item_valid = 1'b1;
        end
      end
      ilid_pkg::MODE_SET: begin
        bad = (pos >= list_len);
        if (!bad)
          list_mem[pos] = word;
      end
      ilid_pkg::MODE_DUMP: ;
      default: bad = 1'b1;
    endcase
    if (bad)
      n_rejects++;
    if (list_len > peak_len)
      peak_len = list_len;
    r.status = bad;
    r.cnt = list_len[4:0];
    if (op == ilid_pkg::MODE_DUMP && list_len > 0) begin
      // one result per entry, in list order
      for (k = 0; k < list_len; k++) begin
        r.word = list_mem[k];
        r.item_valid = 1'b1;
        r.first_item = (k == 0);
        r.last = (k == list_len - 1);
        if (keep)
          pending_q.push_back(r);
      end
    end else if (keep) begin
      pending_q.push_back(r);
    end
  endfunction

  // Entered and left at a falling edge; valid is only lowered before a gap.
  task automatic send_item(input logic [ilid_pkg::MODE_W-1:0] op,
                           input logic [ilid_pkg::POS_W-1:0] pos,
                           input logic [ilid_pkg::WORD_W-1:0] word, input logic fixed,
                           input logic f_status, input logic [4:0] f_cnt);
    list_result_t r;
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 15) == 0)
      src_steady = !src_steady;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, word, pos};
    do @(posedge clk); while (!s_tready);
    apply_list_op(op, pos, word, !fixed);
    if (fixed) begin
      r = '0;
      r.status = f_status;
      r.last = 1'b1;
      r.cnt = f_cnt;
      pending_q.push_back(r);
    end
    n_items++;
    if (op == ilid_pkg::MODE_DUMP)
      n_dumps++;
    @(negedge clk);
  endtask

  task automatic flag_error(input string what);
    err_cnt++;
    $display("%0t ERROR result %0d: %s", $time, n_results, what);
  endtask

  // output side back-pressure
  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0)
        snk_steady = !snk_steady;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        flag_error($sformatf("unexpected item tdata=%h tuser=%b tlast=%b",
                             m_tdata, m_tuser, m_tlast));
      end else begin
        want = pending_q.pop_front();
        if (m_tdata[0] !== want.status)
          flag_error($sformatf("status %b, want %b", m_tdata[0], want.status));
        if (m_tdata[32:1] !== want.word)
          flag_error($sformatf("data %h, want %h", m_tdata[32:1], want.word));
        if (m_tdata[37:33] !== want.cnt)
          flag_error($sformatf("count %0d, want %0d", m_tdata[37:33], want.cnt));
        if (m_tuser[0] !== want.item_valid)
          flag_error($sformatf("item_valid %b, want %b", m_tuser[0], want.item_valid));
        if (m_tuser[1] !== want.first_item)
          flag_error($sformatf("first_item %b, want %b", m_tuser[1], want.first_item));
        if (m_tlast !== want.last)
          flag_error($sformatf("tlast %b, want %b", m_tlast, want.last));
      end
    end
  end

  initial begin
    int n;
    int r;
    int full_tries;
    bit growing;
    logic [ilid_pkg::MODE_W-1:0] op;
    logic [ilid_pkg::POS_W-1:0]  pos;
    logic [ilid_pkg::WORD_W-1:0] word;
    growing = 1'b1;
    full_tries = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].word,
                dir_rows[i].fixed, dir_rows[i].f_status, dir_rows[i].f_cnt);

    // grow to full, poke the full store a few times, then drain to empty
    for (n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        op = MODE_RSV5 + ilid_pkg::MODE_W'($urandom_range(0, 2));
      else if (r < 10)
        op = ilid_pkg::MODE_DUMP;
      else if (r < 20)
        op = ilid_pkg::MODE_GET;
      else if (r < 28)
        op = ilid_pkg::MODE_SET;
      else if (r < 88)
        op = growing ? ilid_pkg::MODE_INSERT : ilid_pkg::MODE_DELETE;
      else
        op = growing ? ilid_pkg::MODE_DELETE : ilid_pkg::MODE_INSERT;

      if ($urandom_range(0, 9) == 0)
        pos = ilid_pkg::POS_W'($urandom_range(0, 16));
      else if (op == ilid_pkg::MODE_INSERT)
        pos = ilid_pkg::POS_W'($urandom_range(0, list_len));
      else
        pos = (list_len == 0) ? '0 : ilid_pkg::POS_W'($urandom_range(0, list_len - 1));

      word = ($urandom_range(0, 19) == 0) ? '0 : $urandom;

      if (growing && list_len == DEPTH && op == ilid_pkg::MODE_INSERT)
        full_tries++;
      send_item(op, pos, word, 1'b0, 1'b0, 5'd0);

      if (growing && full_tries >= 3) begin
        growing = 1'b0;
      end else if (!growing && list_len == 0) begin
        growing = 1'b1;
        full_tries = 0;
      end
    end
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d items (%0d dumps), checked %0d results, %0d mismatches.",
             n_items, n_dumps, n_results, err_cnt);
    $display("Rejected ops: %0d (%0d on a full list); peak list length %0d.",
             n_rejects, n_full_rejects, peak_len);
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", pending_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ilid_pkg.sv
src/ilid_ctrl.sv
src/ilid_dp.sv
src/indexed_list_insert_delete_top.sv
tb/sv/indexed_list_insert_delete_top_tb.sv
